// File: src/adsr_pkg.sv
package adsr_pkg;

    localparam int PHASE_BITS_DEF       = 32;
    localparam int SINE_TABLE_DEPTH_DEF = 256;

    localparam int SR_W = 18;

    localparam logic [15:0] FULL_SCALE = 16'hFFFF;
    localparam logic [31:0] PI_Q30     = 32'd3373259426;

    localparam logic [17:0] SAMPLE_RATE_RESET = 18'd48000;
    localparam logic [15:0] ATTACK_RESET      = 16'd480;
    localparam logic [15:0] DECAY_RESET       = 16'd4800;
    localparam logic [15:0] SUSTAIN_RESET     = 16'd45875;
    localparam logic [15:0] RELEASE_RESET     = 16'd9600;

    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_NOTE_ON  = 2'd1,
        MODE_NOTE_OFF = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ENV_OFF     = 3'd0,
        ENV_ATTACK  = 3'd1,
        ENV_DECAY   = 3'd2,
        ENV_SUSTAIN = 3'd3,
        ENV_RELEASE = 3'd4
    } env_stage_t;

    typedef enum logic [2:0] {
        REG_SAMPLE_RATE = 3'd0,
        REG_ATTACK      = 3'd1,
        REG_DECAY       = 3'd2,
        REG_SUSTAIN     = 3'd3,
        REG_RELEASE     = 3'd4
    } cfg_reg_t;

    // notes 0..11 in q20 hertz
    localparam logic [23:0] NOTE_FREQ_Q20 [12] = '{
        24'd8572947,  24'd9082720,  24'd9622807,  24'd10195009,
        24'd10801236, 24'd11443511, 24'd12123977, 24'd12844906,
        24'd13608704, 24'd14417920, 24'd15275254, 24'd16183568
    };

    function automatic logic [3:0] note_octave(input logic [6:0] n);
        logic [3:0] o;
        o = '0;
        for (int i = 1; i <= 10; i++) begin
            if (n >= 7'(12 * i)) begin
                o = 4'(i);
            end
        end
        return o;
    endfunction

endpackage

// File: src/adsr_div.sv
module adsr_div #(
    parameter  int DIV_W = adsr_pkg::PHASE_BITS_DEF + 15,
    parameter  int Q_W   = 32,
    localparam int CNT_W = $clog2(DIV_W + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [CNT_W-1:0]         iters,
    input  logic [DIV_W-1:0]         dividend,
    input  logic [adsr_pkg::SR_W-1:0] divisor,
    output logic                     idle,
    output logic [Q_W-1:0]           quotient
);

    localparam int SR_W = adsr_pkg::SR_W;

    logic [SR_W:0]    rem_reg, rem_next;
    logic [DIV_W-1:0] num_reg, num_next;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic [SR_W-1:0]  dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SR_W:0]    trial;
    logic             fits;

    // one quotient bit per cycle, msb first
    assign trial = {rem_reg[SR_W-1:0], num_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        rem_next = rem_reg;
        num_next = num_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (start) begin
            rem_next = '0;
            num_next = dividend;
            quo_next = '0;
            cnt_next = iters;
        end else if (cnt_reg != '0) begin
            rem_next = fits ? (trial - {1'b0, dvs_reg}) : trial;
            num_next = {num_reg[DIV_W-2:0], 1'b0};
            quo_next = {quo_reg[Q_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign idle     = (cnt_reg == '0);
    assign quotient = quo_reg;

    ap_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0 && !$past(start)) |-> (rem_reg < {1'b0, dvs_reg}))
        else $error("partial remainder not below divisor");

endmodule

// File: src/adsr_sine_oscillator.sv
// channel  | dir | handshake               | beat content
// s_       | in  | s_tvalid / s_tready     | tuser: mode; tdata: note_number
// m_       | out | m_tvalid / m_tready     | tdata: sample, envelope
// cfg_     | in  | cfg_valid / cfg_ready   | cfg_index, cfg_wdata
//
// a tick beat in attack and decay, and in release before its last tick, runs the states
// mul, div (the bit-serial divider), env, scale, bias and emit; in sustain and off it skips div
// a note-on beat runs div and step, one divider step per phase step dividend bit
// a note-off beat and a mode three beat leave the state machine in idle
// reset is synchronous, active low; no clearing pass, the sine table is constant logic
// a stalled result waits in the output register; the next beat is taken as soon as the
// current one has moved its result there
module adsr_sine_oscillator #(
    parameter int PHASE_BITS       = adsr_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = adsr_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [6:0] note_number
    input  logic [1:0]  s_tuser,    // [1:0] mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [15:0] sample, [31:16] envelope

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [17:0] cfg_wdata
);

    localparam int DIV_W     = PHASE_BITS + 15;
    localparam int Q_W       = (PHASE_BITS > 32) ? PHASE_BITS : 32;
    localparam int CNT_W     = $clog2(DIV_W + 1);
    localparam int FRAC_W    = PHASE_BITS - 2;
    localparam int IDX_W     = $clog2(SINE_TABLE_DEPTH);
    localparam int DEPTH_W   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int FPROD_W   = FRAC_W + DEPTH_W;
    localparam int ENV_ITERS = 32;
    localparam int SR_W      = adsr_pkg::SR_W;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL   = 8'b0000_0010,
        ST_DIV   = 8'b0000_0100,
        ST_STEP  = 8'b0000_1000,
        ST_ENV   = 8'b0001_0000,
        ST_SCALE = 8'b0010_0000,
        ST_BIAS  = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    function automatic logic [14:0] rom_entry(input int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        x  = (64'(adsr_pkg::PI_Q30) * (64'(i) * 64'd2 + 64'd1)
              + 64'(2 * SINE_TABLE_DEPTH)) / 64'(4 * SINE_TABLE_DEPTH);
        x2 = (x * x) >> 30;
        t  = x;
        s  = x;
        for (int n = 1; n <= 8; n++) begin
            t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                s = s - t;
            end else begin
                s = s + t;
            end
        end
        v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        return (v > 64'd32767) ? 15'h7FFF : v[14:0];
    endfunction

    // configuration registers
    logic [17:0] sr_reg;
    logic [15:0] attack_reg, decay_reg, sustain_reg, release_reg;

    // control state
    state_t                 state_reg, state_next;
    adsr_pkg::env_stage_t   stage_reg, stage_next;
    logic [15:0]            count_reg, count_next;
    logic [PHASE_BITS-1:0]  phase_reg, phase_next;
    logic [PHASE_BITS-1:0]  step_reg, step_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    // per-beat payload
    logic                   note_reg;
    logic                   need_div_reg;
    adsr_pkg::env_stage_t   kind_reg;
    logic [15:0]            mul_a_reg, mul_b_reg;
    logic [15:0]            div_len_reg;
    logic [15:0]            span_reg;
    logic [15:0]            env_reg;
    logic [FPROD_W-1:0]     fprod_reg;
    logic [1:0]             quad_reg;
    logic [14:0]            sin_reg;
    logic [30:0]            scale_reg;
    logic [31:0]            bias_reg;
    logic [31:0]            m_tdata_reg;

    logic                   in_accept, is_tick, is_note_on;
    logic                   out_free, out_load;
    logic [15:0]            a_eff, d_eff, r_eff, span;
    logic [16:0]            nc;
    logic                   tick_div;
    logic [15:0]            tick_env, op_a, op_b, tick_len;
    logic [17:0]            sr_eff;
    logic [3:0]             octave;
    logic [6:0]             key;
    logic [DIV_W-1:0]       note_num, note_dividend;
    logic [31:0]            env_prod;
    logic                   div_start, div_idle;
    logic [CNT_W-1:0]       div_iters;
    logic [DIV_W-1:0]       div_dividend;
    logic [SR_W-1:0]        div_divisor;
    logic [Q_W-1:0]         div_quo;
    logic [15:0]            env_q, drop;
    logic [IDX_W-1:0]       idx_raw, rom_idx;
    logic [32:0]            recip_sum;
    logic [15:0]            mag;
    logic [15:0]            sample_val;
    logic [15:0]            out_abs;
    logic [14:0]            sine_rom [SINE_TABLE_DEPTH];

    for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
        localparam logic [14:0] ROM_VAL = rom_entry(gi);
        assign sine_rom[gi] = ROM_VAL;
    end

    assign in_accept   = s_tvalid && s_tready;
    assign is_tick     = (s_tuser == adsr_pkg::MODE_TICK);
    assign is_note_on  = (s_tuser == adsr_pkg::MODE_NOTE_ON);
    assign s_tready    = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_free    = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sr_reg      <= adsr_pkg::SAMPLE_RATE_RESET;
            attack_reg  <= adsr_pkg::ATTACK_RESET;
            decay_reg   <= adsr_pkg::DECAY_RESET;
            sustain_reg <= adsr_pkg::SUSTAIN_RESET;
            release_reg <= adsr_pkg::RELEASE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                adsr_pkg::REG_SAMPLE_RATE: sr_reg      <= cfg_wdata;
                adsr_pkg::REG_ATTACK:      attack_reg  <= cfg_wdata[15:0];
                adsr_pkg::REG_DECAY:       decay_reg   <= cfg_wdata[15:0];
                adsr_pkg::REG_SUSTAIN:     sustain_reg <= cfg_wdata[15:0];
                adsr_pkg::REG_RELEASE:     release_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // envelope step taken when a beat is accepted
    assign a_eff = (attack_reg == '0) ? 16'd1 : attack_reg;
    assign d_eff = (decay_reg == '0) ? 16'd1 : decay_reg;
    assign r_eff = (release_reg == '0) ? 16'd1 : release_reg;
    assign span  = adsr_pkg::FULL_SCALE - sustain_reg;
    assign nc    = {1'b0, count_reg} + 17'd1;

    always_comb begin
        stage_next = stage_reg;
        count_next = count_reg;
        tick_div   = 1'b0;
        tick_env   = '0;
        op_a       = count_reg;
        op_b       = adsr_pkg::FULL_SCALE;
        tick_len   = a_eff;
        if (in_accept) begin
            case (s_tuser)
                adsr_pkg::MODE_TICK: begin
                    case (stage_reg)
                        adsr_pkg::ENV_ATTACK: begin
                            tick_div = 1'b1;
                            if (nc >= {1'b0, a_eff}) begin
                                stage_next = adsr_pkg::ENV_DECAY;
                                count_next = '0;
                            end else begin
                                count_next = nc[15:0];
                            end
                        end
                        adsr_pkg::ENV_DECAY: begin
                            tick_div = 1'b1;
                            op_a     = span;
                            op_b     = count_reg;
                            tick_len = d_eff;
                            if (nc >= {1'b0, d_eff}) begin
                                stage_next = adsr_pkg::ENV_SUSTAIN;
                                count_next = '0;
                            end else begin
                                count_next = nc[15:0];
                            end
                        end
                        adsr_pkg::ENV_SUSTAIN: begin
                            tick_env = sustain_reg;
                        end
                        adsr_pkg::ENV_RELEASE: begin
                            if (nc >= {1'b0, r_eff}) begin
                                stage_next = adsr_pkg::ENV_OFF;
                                count_next = nc[16] ? 16'hFFFF : nc[15:0];
                            end else begin
                                tick_div   = 1'b1;
                                op_a       = sustain_reg;
                                op_b       = r_eff - count_reg;
                                tick_len   = r_eff;
                                count_next = nc[15:0];
                            end
                        end
                        default: ;
                    endcase
                end
                adsr_pkg::MODE_NOTE_ON: begin
                    stage_next = adsr_pkg::ENV_ATTACK;
                    count_next = '0;
                end
                adsr_pkg::MODE_NOTE_OFF: begin
                    stage_next = adsr_pkg::ENV_RELEASE;
                    count_next = '0;
                end
                default: ;
            endcase
        end
    end

    // phase step dividend for a note on
    assign sr_eff        = (sr_reg == '0) ? 18'd1 : sr_reg;
    assign octave        = adsr_pkg::note_octave(s_tdata[6:0]);
    assign key           = s_tdata[6:0] - 7'(octave) * 7'd12;
    assign note_num      = (DIV_W'(adsr_pkg::NOTE_FREQ_Q20[key[3:0]]) << octave)
                           << (PHASE_BITS - 20);
    assign note_dividend = note_num + DIV_W'(sr_eff >> 1);

    assign env_prod = 32'(mul_a_reg) * 32'(mul_b_reg);

    assign div_start    = (in_accept && is_note_on) || (state_reg == ST_MUL && need_div_reg);
    assign div_dividend = (state_reg == ST_IDLE) ? note_dividend
                                                 : {env_prod, {(DIV_W - 32){1'b0}}};
    assign div_divisor  = (state_reg == ST_IDLE) ? sr_eff : {2'b00, div_len_reg};
    assign div_iters    = (state_reg == ST_IDLE) ? CNT_W'(DIV_W) : CNT_W'(ENV_ITERS);

    adsr_div #(
        .DIV_W (DIV_W),
        .Q_W   (Q_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .iters    (div_iters),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .idle     (div_idle),
        .quotient (div_quo)
    );

    // envelope from the quotient, ramps clamped at their ends
    always_comb begin
        drop  = '0;
        env_q = div_quo[15:0];
        case (kind_reg)
            adsr_pkg::ENV_ATTACK: begin
                env_q = (div_quo[31:0] > 32'(adsr_pkg::FULL_SCALE)) ? adsr_pkg::FULL_SCALE
                                                                   : div_quo[15:0];
            end
            adsr_pkg::ENV_DECAY: begin
                drop  = (div_quo[31:0] > 32'(span_reg)) ? span_reg : div_quo[15:0];
                env_q = adsr_pkg::FULL_SCALE - drop;
            end
            default: ;
        endcase
    end

    // quarter-wave lookup
    assign idx_raw = IDX_W'(fprod_reg >> FRAC_W);
    assign rom_idx = quad_reg[0] ? (IDX_W'(SINE_TABLE_DEPTH - 1) - idx_raw) : idx_raw;

    // divide by 65535 as (x + (x >> 16) + 1) >> 16
    assign recip_sum  = 33'(bias_reg) + 33'(bias_reg >> 16) + 33'd1;
    assign mag        = recip_sum[31:16];
    assign sample_val = quad_reg[1] ? (16'd0 - mag) : mag;

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && is_tick) begin
                    state_next = ST_MUL;
                end else if (in_accept && is_note_on) begin
                    state_next = ST_DIV;
                end
            end
            ST_MUL: begin
                state_next = need_div_reg ? ST_DIV : ST_ENV;
            end
            ST_DIV: begin
                if (div_idle) begin
                    state_next = note_reg ? ST_STEP : ST_ENV;
                end
            end
            ST_STEP: begin
                state_next = ST_IDLE;
            end
            ST_ENV: begin
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                state_next = ST_BIAS;
            end
            ST_BIAS: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign phase_next    = (in_accept && is_tick) ? (phase_reg + step_reg) : phase_reg;
    assign step_next     = (state_reg == ST_STEP) ? div_quo[PHASE_BITS-1:0] : step_reg;
    assign m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            stage_reg    <= adsr_pkg::ENV_OFF;
            count_reg    <= '0;
            phase_reg    <= '0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            stage_reg    <= stage_next;
            count_reg    <= count_next;
            phase_reg    <= phase_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            note_reg <= is_note_on;
        end
        if (in_accept && is_tick) begin
            need_div_reg <= tick_div;
            kind_reg     <= stage_reg;
            mul_a_reg    <= op_a;
            mul_b_reg    <= op_b;
            div_len_reg  <= tick_len;
            span_reg     <= span;
            env_reg      <= tick_env;
            fprod_reg    <= FPROD_W'(phase_reg[FRAC_W-1:0]) * FPROD_W'(SINE_TABLE_DEPTH);
            quad_reg     <= phase_reg[PHASE_BITS-1:PHASE_BITS-2];
        end
        if (state_reg == ST_ENV && need_div_reg) begin
            env_reg <= env_q;
        end
        sin_reg <= sine_rom[rom_idx];
        if (state_reg == ST_SCALE) begin
            scale_reg <= 31'(sin_reg) * 31'(env_reg);
        end
        if (state_reg == ST_BIAS) begin
            bias_reg <= 32'(scale_reg) + 32'd32767;
        end
        if (out_load) begin
            m_tdata_reg <= {env_reg, sample_val};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign out_abs = m_tdata_reg[15] ? (16'd0 - m_tdata_reg[15:0]) : m_tdata_reg[15:0];

    ap_idle_divider: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> div_idle)
        else $error("divider busy while taking beats");

    ap_note_on_attack: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && is_note_on) |=> (state_reg == ST_DIV && stage_reg == adsr_pkg::ENV_ATTACK))
        else $error("note on did not start attack and step division");

    ap_sample_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (out_abs <= ((m_tdata_reg[31:16] >> 1) + 16'd1)))
        else $error("sample magnitude exceeds envelope");

    ap_emit_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && m_tvalid_reg && !m_tready) |=> (state_reg == ST_EMIT))
        else $error("result overwrote a waiting beat");

endmodule

// File: tb/sv/adsr_sine_oscillator_chk.sv
`timescale 1ns / 100ps

module adsr_sine_oscillator_chk
    import adsr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [17:0] cfg_wdata,

    output int          mismatches,
    output int          samples_pending,
    output int          samples_checked
);

    localparam int TABLE_DEPTH = SINE_TABLE_DEPTH_DEF;
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        logic [15:0] sample;
        logic [15:0] level;
    } voice_out_t;

    logic [15:0]  sine_rom [TABLE_DEPTH];

    logic [17:0]  rate_q;
    logic [15:0]  attack_q;
    logic [15:0]  decay_q;
    logic [15:0]  sustain_q;
    logic [15:0]  release_q;

    env_stage_t   stage_q;
    int unsigned  count_q;
    logic [31:0]  phase_q;
    logic [31:0]  step_q;

    voice_out_t   samples_due[$];

    // quarter-wave entry from a q30 taylor series, terms truncated
    function automatic logic [15:0] quarter_sine(input int i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        x  = (64'(PI_Q30) * 64'(2 * i + 1) + 64'(2 * TABLE_DEPTH)) / 64'(4 * TABLE_DEPTH);
        x2 = (x * x) >> 30;
        t  = x;
        s  = x;
        for (int n = 1; n <= 8; n++) begin
            t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                s = s - t;
            end else begin
                s = s + t;
            end
        end
        v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        return (v > 64'd32767) ? 16'd32767 : v[15:0];
    endfunction

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            sine_rom[i] = quarter_sine(i);
        end
    end

    function automatic logic [31:0] note_phase_step(input logic [6:0] note);
        int              octave;
        int              key;
        longint unsigned num;
        longint unsigned sr;
        octave = int'(note) / 12;
        key    = int'(note) % 12;
        num    = (64'(NOTE_FREQ_Q20[key]) << octave) << (PHASE_BITS_DEF - 20);
        sr     = (rate_q == '0) ? 64'd1 : 64'(rate_q);
        return 32'((num + sr / 2) / sr);
    endfunction

    function automatic int sine_lookup(input logic [31:0] ph);
        int idx;
        int mag;
        idx = int'((64'(ph[29:0]) * TABLE_DEPTH) >> 30);
        if (idx >= TABLE_DEPTH) begin
            idx = TABLE_DEPTH - 1;
        end
        // odd quadrants run the table backward, upper half is negative
        if (ph[30]) begin
            idx = TABLE_DEPTH - 1 - idx;
        end
        mag = int'(sine_rom[idx]);
        return ph[31] ? -mag : mag;
    endfunction

    function automatic int unsigned advance_envelope();
        int unsigned a;
        int unsigned d;
        int unsigned r;
        int unsigned s;
        int unsigned c;
        int unsigned nc;
        int unsigned e;
        int unsigned span;
        int unsigned drop;
        a  = (attack_q == '0) ? 1 : attack_q;
        d  = (decay_q == '0) ? 1 : decay_q;
        r  = (release_q == '0) ? 1 : release_q;
        s  = sustain_q;
        c  = count_q;
        nc = count_q + 1;
        case (stage_q)
            ENV_ATTACK: begin
                e = 32'((64'(c) * 64'(FULL_SCALE)) / 64'(a));
                if (e > FULL_SCALE) begin
                    e = FULL_SCALE;
                end
                if (nc >= a) begin
                    stage_q = ENV_DECAY;
                    count_q = 0;
                end else begin
                    count_q = nc;
                end
                return e;
            end
            ENV_DECAY: begin
                span = FULL_SCALE - s;
                drop = 32'((64'(span) * 64'(c)) / 64'(d));
                if (drop > span) begin
                    drop = span;
                end
                if (nc >= d) begin
                    stage_q = ENV_SUSTAIN;
                    count_q = 0;
                end else begin
                    count_q = nc;
                end
                return FULL_SCALE - drop;
            end
            ENV_SUSTAIN: begin
                return s;
            end
            ENV_RELEASE: begin
                e = (c >= r) ? 0 : 32'((64'(s) * 64'(r - c)) / 64'(r));
                if (nc >= r) begin
                    stage_q = ENV_OFF;
                    count_q = (nc > 32'hFFFF) ? 32'hFFFF : nc;
                    return 0;
                end
                count_q = nc;
                return e;
            end
            default: begin
                return 0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    initial begin
        mismatches      = 0;
        samples_pending = 0;
        samples_checked = 0;
    end

    always @(posedge aclk) begin
        int unsigned     level;
        int              sn;
        longint unsigned mag;
        int              smp;
        voice_out_t      want;
        if (!aresetn) begin
            rate_q    = SAMPLE_RATE_RESET;
            attack_q  = ATTACK_RESET;
            decay_q   = DECAY_RESET;
            sustain_q = SUSTAIN_RESET;
            release_q = RELEASE_RESET;
            stage_q   = ENV_OFF;
            count_q   = 0;
            phase_q   = '0;
            step_q    = '0;
            samples_due.delete();
        end else begin
            // output beat first: it can only belong to an earlier input beat
            if (m_tvalid && m_tready) begin
                if (samples_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat sample %0d envelope %0d",
                        $signed(m_tdata[15:0]), m_tdata[31:16]));
                end else begin
                    want = samples_due.pop_front();
                    if (m_tdata[15:0] !== want.sample) begin
                        report_mismatch($sformatf("sample %0d, want %0d (beat %0d)",
                            $signed(m_tdata[15:0]), $signed(want.sample), samples_checked));
                    end
                    if (m_tdata[31:16] !== want.level) begin
                        report_mismatch($sformatf("envelope %0d, want %0d (beat %0d)",
                            m_tdata[31:16], want.level, samples_checked));
                    end
                    samples_checked++;
                end
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SAMPLE_RATE: rate_q    = cfg_wdata;
                    REG_ATTACK:      attack_q  = cfg_wdata[15:0];
                    REG_DECAY:       decay_q   = cfg_wdata[15:0];
                    REG_SUSTAIN:     sustain_q = cfg_wdata[15:0];
                    REG_RELEASE:     release_q = cfg_wdata[15:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    MODE_NOTE_ON: begin
                        step_q  = note_phase_step(s_tdata[6:0]);
                        stage_q = ENV_ATTACK;
                        count_q = 0;
                    end
                    MODE_NOTE_OFF: begin
                        stage_q = ENV_RELEASE;
                        count_q = 0;
                    end
                    MODE_TICK: begin
                        level = advance_envelope();
                        sn    = sine_lookup(phase_q);
                        mag   = (sn < 0) ? 64'(-sn) : 64'(sn);
                        mag   = (mag * 64'(level) + 64'd32767) / 64'(FULL_SCALE);
                        smp   = (sn < 0) ? -int'(mag) : int'(mag);
                        want.sample = 16'(smp);
                        want.level  = 16'(level);
                        samples_due.push_back(want);
                        phase_q = phase_q + step_q;
                    end
                    default: ;
                endcase
            end
        end
        samples_pending = samples_due.size();
    end

endmodule

// File: tb/sv/adsr_sine_oscillator_tb.sv
`timescale 1ns / 100ps

module adsr_sine_oscillator_tb;
    import adsr_pkg::*;

    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         SETTLE       = 64;
    localparam int         IDLE_PERCENT = 7;
    localparam int         PHASES       = 8;
    localparam int         PHASE_BEATS  = 200;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;

    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;

    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [17:0] cfg_wdata = '0;

    int          mismatches;
    int          samples_pending;
    int          samples_checked;

    int          cycles        = 0;
    bit          quiet         = 1'b0;
    int          beats_sent    = 0;
    int          settings_used = 0;

    adsr_sine_oscillator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    adsr_sine_oscillator_chk i_chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .samples_pending (samples_pending),
        .samples_checked (samples_checked)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("run stopped after %0d cycles, %0d samples still due", cycles,
            samples_pending);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic bit idle_roll();
        return !quiet && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    always @(negedge aclk) begin
        m_tready = !idle_roll();
    end

    // leaves the beat on the bus, the next call either replaces it or idles
    task automatic push_beat(input logic [1:0] mode, input logic [6:0] note);
        while (idle_roll()) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = {1'b0, note};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        if (mode != MODE_UNUSED) begin
            beats_sent++;
        end
        @(negedge aclk);
    endtask

    task automatic tick_beats(input int n);
        repeat (n) begin
            push_beat(MODE_TICK, 7'($urandom_range(127)));
        end
    endtask

    // note-on work has no result beat, so give it time after the last sample
    task automatic drain();
        s_tvalid = 1'b0;
        while (samples_pending != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [17:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_voice(input logic [17:0] rate, input logic [15:0] atk,
                              input logic [15:0] dcy, input logic [15:0] sus,
                              input logic [15:0] rel);
        drain();
        write_reg(REG_SAMPLE_RATE, rate);
        write_reg(REG_ATTACK, 18'(atk));
        write_reg(REG_DECAY, 18'(dcy));
        write_reg(REG_SUSTAIN, 18'(sus));
        write_reg(REG_RELEASE, 18'(rel));
        settings_used++;
    endtask

    function automatic logic [15:0] pick_length();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(65535));
            default: return 16'($urandom_range(24, 1));
        endcase
    endfunction

    task automatic play_phrase();
        int held;
        int tail;
        held = $urandom_range(40, 1);
        tail = $urandom_range(40);
        push_beat(MODE_NOTE_ON, 7'($urandom_range(127)));
        tick_beats(held);
        if ($urandom_range(3) != 0) begin
            push_beat(MODE_NOTE_OFF, 7'($urandom_range(127)));
        end
        tick_beats(tail);
    endtask

    initial begin
        int          target;
        logic [17:0] rate;
        logic [15:0] sus;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: silence, release from sustain while off, note range ends
        tick_beats(2);
        push_beat(MODE_UNUSED, 7'h7F);
        push_beat(MODE_NOTE_OFF, 7'h00);
        tick_beats(2);
        push_beat(MODE_NOTE_ON, 7'd0);
        tick_beats(2);
        push_beat(MODE_NOTE_ON, 7'd127);
        tick_beats(1);
        push_beat(MODE_NOTE_ON, 7'd69);
        tick_beats(1);

        // zero rate and zero lengths, step wraps, full sustain
        load_voice(18'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0);
        push_beat(MODE_NOTE_ON, 7'd127);
        tick_beats(4);
        push_beat(MODE_NOTE_OFF, 7'd0);
        tick_beats(2);

        // attack cut short mid-ramp, then a rate change after the note started
        load_voice(18'd192000, 16'd10, 16'd3, 16'd0, 16'd4);
        push_beat(MODE_NOTE_ON, 7'd60);
        tick_beats(5);
        drain();
        write_reg(REG_ATTACK, 18'd2);
        tick_beats(2);
        drain();
        write_reg(REG_SAMPLE_RATE, 18'd8000);
        tick_beats(1);

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(4))
                0:       rate = 18'd8000;
                1:       rate = 18'd192000;
                2:       rate = 18'd0;
                3:       rate = 18'h3FFFF;
                default: rate = 18'($urandom_range(192000, 8000));
            endcase
            case ($urandom_range(3))
                0:       sus = 16'd0;
                1:       sus = 16'hFFFF;
                default: sus = 16'($urandom_range(65535));
            endcase
            load_voice(rate, pick_length(), pick_length(), sus, pick_length());
            quiet  = (ph == 3);
            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target) begin
                if ($urandom_range(9) < 8) begin
                    play_phrase();
                end else begin
                    push_beat(2'($urandom_range(3)), 7'($urandom_range(127)));
                end
            end
        end
        quiet = 1'b0;

        drain();
        $display("%0d input beats sent, %0d sample beats checked over %0d register settings",
            beats_sent, samples_checked, settings_used);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
